// ===== hdl/uds_sf_pkg.sv =====
// Shared types and constants of the UDS single-frame responder.
`timescale 1ns / 1ps

package uds_sf_pkg;

   localparam logic [7:0] SID_SESSION   = 8'h10;
   localparam logic [7:0] SID_ECU_RESET = 8'h11;
   localparam logic [7:0] SID_READ_DID  = 8'h22;
   localparam logic [7:0] SID_TESTER    = 8'h3E;

   localparam logic [7:0] RSP_NEGATIVE  = 8'h7F;
   localparam logic [7:0] RSP_SESSION   = 8'h50;
   localparam logic [7:0] RSP_ECU_RESET = 8'h51;
   localparam logic [7:0] RSP_READ_DID  = 8'h62;
   localparam logic [7:0] RSP_TESTER    = 8'h7E;

   localparam logic [7:0] NRC_SERVICE_NOT_SUPPORTED = 8'h11;
   localparam logic [7:0] NRC_BAD_LENGTH            = 8'h13;
   localparam logic [7:0] NRC_OUT_OF_RANGE          = 8'h31;

   localparam logic [7:0] TP_SUPPRESS = 8'h80;

   localparam logic [15:0] DID_APP_VERSION  = 16'hF180;
   localparam logic [15:0] DID_BOOT_VERSION = 16'hF194;

   // session timing: P2 = 0x0032, P2* = 0x01F4
   localparam logic [7:0] P2_HIGH      = 8'h00;
   localparam logic [7:0] P2_LOW       = 8'h32;
   localparam logic [7:0] P2_STAR_HIGH = 8'h01;
   localparam logic [7:0] P2_STAR_LOW  = 8'hF4;

   localparam logic [7:0] SESSION_DEFAULT = 8'h01;

   localparam logic [10:0] PHYS_ID_RESET = 11'h735;
   localparam logic [10:0] FUNC_ID_RESET = 11'h7DF;

   localparam logic [2:0] REG_PHYS_ID    = 3'd0;
   localparam logic [2:0] REG_FUNC_ID    = 3'd1;
   localparam logic [2:0] REG_APP_MAJOR  = 3'd2;
   localparam logic [2:0] REG_APP_MINOR  = 3'd3;
   localparam logic [2:0] REG_BOOT_MAJOR = 3'd4;
   localparam logic [2:0] REG_BOOT_MINOR = 3'd5;

   typedef enum logic [2:0] {
      KIND_NEGATIVE,
      KIND_SESSION,
      KIND_ECU_RESET,
      KIND_APP_VERSION,
      KIND_BOOT_VERSION,
      KIND_TESTER
   } kind_type;

   // accepted frame after address and length filtering
   typedef struct packed {
      logic [2:0] plen;
      logic [7:0] sid;
      logic [7:0] p2;
      logic [7:0] p3;
   } frame_type;

   // decoded response class
   typedef struct packed {
      kind_type   kind;
      logic [7:0] sid;
      logic [7:0] nrc;
      logic [7:0] p2;
      logic [7:0] p3;
   } decode_type;

endpackage

// ===== hdl/uds_sf_filter.sv =====
// Stage 1: identifier match and single-frame length check.
`timescale 1ns / 1ps

module uds_sf_filter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [10:0]            can_id,
   input  logic [3:0]             frame_length,
   input  logic [7:0]             data_byte0,
   input  logic [7:0]             data_byte1,
   input  logic [7:0]             data_byte2,
   input  logic [7:0]             data_byte3,
   input  logic [10:0]            phys_id,
   input  logic [10:0]            func_id,
   output logic                   out_valid,
   input  logic                   out_ready,
   output uds_sf_pkg::frame_type  out_frame
);

   logic                  valid_ff, valid_in;
   uds_sf_pkg::frame_type frame_ff, frame_in;
   logic                  id_hit, len_ok;
   logic [3:0]            nibble;
   logic [3:0]            need;

   assign nibble = data_byte0[3:0];
   assign need   = nibble + 4'd1;
   assign id_hit = (can_id == phys_id) || (can_id == func_id);
   // nibble 1..7 and nibble + 1 bytes present
   assign len_ok = (nibble != 4'd0) && !nibble[3] && (need <= frame_length);

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in       = in_valid && id_hit && len_ok;
      frame_in.plen  = nibble[2:0];
      frame_in.sid   = data_byte1;
      frame_in.p2    = data_byte2;
      frame_in.p3    = data_byte3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         frame_ff <= frame_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_frame = frame_ff;

endmodule

// ===== hdl/uds_sf_decode.sv =====
// Stage 2: service decode and session state.
`timescale 1ns / 1ps

module uds_sf_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  uds_sf_pkg::frame_type  in_frame,
   output logic                   out_valid,
   input  logic                   out_ready,
   output uds_sf_pkg::decode_type out_dec
);

   logic                   valid_ff, valid_in;
   uds_sf_pkg::decode_type dec_ff, dec_in;
   logic [7:0]             session_type_ff, session_type_in;
   logic                   has_p2, has_p3, set_session;
   logic [15:0]            did;

   assign in_ready = !valid_ff || out_ready;
   assign has_p2   = in_frame.plen >= 3'd2;
   assign has_p3   = in_frame.plen >= 3'd3;
   assign did      = {in_frame.p2, in_frame.p3};

   assign set_session = in_valid && in_ready && has_p2
                        && (in_frame.sid == uds_sf_pkg::SID_SESSION);
   assign session_type_in = set_session ? in_frame.p2 : session_type_ff;

   always_comb begin
      valid_in    = in_valid;
      dec_in.kind = uds_sf_pkg::KIND_NEGATIVE;
      dec_in.sid  = in_frame.sid;
      dec_in.nrc  = uds_sf_pkg::NRC_SERVICE_NOT_SUPPORTED;
      dec_in.p2   = in_frame.p2;
      dec_in.p3   = in_frame.p3;
      unique case (in_frame.sid)
         uds_sf_pkg::SID_SESSION: begin
            if (has_p2) begin
               dec_in.kind = uds_sf_pkg::KIND_SESSION;
               dec_in.p2   = session_type_in;
            end else begin
               dec_in.nrc  = uds_sf_pkg::NRC_BAD_LENGTH;
            end
         end
         uds_sf_pkg::SID_ECU_RESET: begin
            dec_in.kind = uds_sf_pkg::KIND_ECU_RESET;
            valid_in    = in_valid && has_p2;
         end
         uds_sf_pkg::SID_READ_DID: begin
            valid_in = in_valid && has_p3;
            if (did == uds_sf_pkg::DID_APP_VERSION) begin
               dec_in.kind = uds_sf_pkg::KIND_APP_VERSION;
            end else if (did == uds_sf_pkg::DID_BOOT_VERSION) begin
               dec_in.kind = uds_sf_pkg::KIND_BOOT_VERSION;
            end else begin
               dec_in.nrc  = uds_sf_pkg::NRC_OUT_OF_RANGE;
            end
         end
         uds_sf_pkg::SID_TESTER: begin
            dec_in.kind = uds_sf_pkg::KIND_TESTER;
            // suppress-positive-response bit set as the whole sub-function
            valid_in    = in_valid && !(has_p2 && in_frame.p2 == uds_sf_pkg::TP_SUPPRESS);
         end
         default: begin
            dec_in.kind = uds_sf_pkg::KIND_NEGATIVE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         session_type_ff <= uds_sf_pkg::SESSION_DEFAULT;
      end else begin
         session_type_ff <= session_type_in;
         if (in_ready) begin
            valid_ff <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         dec_ff <= dec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_dec   = dec_ff;

endmodule

// ===== hdl/uds_sf_format.sv =====
// Stage 3: response frame assembly into the output register.
`timescale 1ns / 1ps

module uds_sf_format (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  uds_sf_pkg::decode_type in_dec,
   input  logic [7:0]             app_major,
   input  logic [7:0]             app_minor,
   input  logic [7:0]             boot_major,
   input  logic [7:0]             boot_minor,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [2:0]             out_len,
   output logic [6:0][7:0]        out_bytes,
   output logic                   out_reset_req
);

   logic            valid_ff;
   logic [2:0]      len_ff, len_in;
   logic [6:0][7:0] bytes_ff, bytes_in;
   logic            rst_ff, rst_in;

   assign in_ready = !valid_ff || out_ready;

   // bytes_in[0] is frame byte 1
   always_comb begin
      len_in   = 3'd3;
      bytes_in = '0;
      rst_in   = 1'b0;
      unique case (in_dec.kind)
         uds_sf_pkg::KIND_NEGATIVE: begin
            len_in      = 3'd3;
            bytes_in[0] = uds_sf_pkg::RSP_NEGATIVE;
            bytes_in[1] = in_dec.sid;
            bytes_in[2] = in_dec.nrc;
         end
         uds_sf_pkg::KIND_SESSION: begin
            len_in      = 3'd6;
            bytes_in[0] = uds_sf_pkg::RSP_SESSION;
            bytes_in[1] = in_dec.p2;
            bytes_in[2] = uds_sf_pkg::P2_HIGH;
            bytes_in[3] = uds_sf_pkg::P2_LOW;
            bytes_in[4] = uds_sf_pkg::P2_STAR_HIGH;
            bytes_in[5] = uds_sf_pkg::P2_STAR_LOW;
         end
         uds_sf_pkg::KIND_ECU_RESET: begin
            len_in      = 3'd2;
            bytes_in[0] = uds_sf_pkg::RSP_ECU_RESET;
            bytes_in[1] = in_dec.p2;
            rst_in      = 1'b1;
         end
         uds_sf_pkg::KIND_APP_VERSION: begin
            len_in      = 3'd5;
            bytes_in[0] = uds_sf_pkg::RSP_READ_DID;
            bytes_in[1] = in_dec.p2;
            bytes_in[2] = in_dec.p3;
            bytes_in[3] = app_major;
            bytes_in[4] = app_minor;
         end
         uds_sf_pkg::KIND_BOOT_VERSION: begin
            len_in      = 3'd5;
            bytes_in[0] = uds_sf_pkg::RSP_READ_DID;
            bytes_in[1] = in_dec.p2;
            bytes_in[2] = in_dec.p3;
            bytes_in[3] = boot_major;
            bytes_in[4] = boot_minor;
         end
         uds_sf_pkg::KIND_TESTER: begin
            len_in      = 3'd1;
            bytes_in[0] = uds_sf_pkg::RSP_TESTER;
         end
         default: begin
            len_in = 3'd3;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         len_ff   <= len_in;
         bytes_ff <= bytes_in;
         rst_ff   <= rst_in;
      end
   end

   assign out_valid     = valid_ff;
   assign out_len       = len_ff;
   assign out_bytes     = bytes_ff;
   assign out_reset_req = rst_ff;

endmodule

// ===== hdl/uds_single_frame_responder.sv =====
// Top level of the UDS single-frame responder with its configuration registers.
`timescale 1ns / 1ps

// Takes one classic CAN frame per cycle on the req_ channel and answers with one
// zero-padded single-frame response on the rsp_ channel, or with nothing when the
// frame is not addressed to this node, is malformed, or asks for no answer (a
// session control request without a sub-function gets negative response 0x13).
// The pipeline has three register stages (filter, service decode, frame assembly),
// through which each response passes in that order; a new request is taken every
// cycle as long as the response side keeps up, and a stall on rsp_ready holds
// every stage without loss. Session control, ECU reset (with a reset_request flag
// on the response), read of the F180/F194 version identifiers and tester present
// are served; other services get negative response 0x11. The csr_ port is always
// ready and should be written only while no request is in flight.

module uds_single_frame_responder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [10:0] req_can_id,
   input  logic [3:0]  req_frame_length,
   input  logic [7:0]  req_data_byte0,
   input  logic [7:0]  req_data_byte1,
   input  logic [7:0]  req_data_byte2,
   input  logic [7:0]  req_data_byte3,
   input  logic [7:0]  req_data_byte4,
   input  logic [7:0]  req_data_byte5,
   input  logic [7:0]  req_data_byte6,
   input  logic [7:0]  req_data_byte7,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_resp_byte0,
   output logic [7:0]  rsp_resp_byte1,
   output logic [7:0]  rsp_resp_byte2,
   output logic [7:0]  rsp_resp_byte3,
   output logic [7:0]  rsp_resp_byte4,
   output logic [7:0]  rsp_resp_byte5,
   output logic [7:0]  rsp_resp_byte6,
   output logic [7:0]  rsp_resp_byte7,
   output logic        rsp_reset_request,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_data
);

   logic [10:0] phys_id_ff, func_id_ff;
   logic [7:0]  app_major_ff, app_minor_ff, boot_major_ff, boot_minor_ff;
   logic        csr_we;

   logic                   s1_valid, s1_ready;
   uds_sf_pkg::frame_type  s1_frame;
   logic                   s2_valid, s2_ready;
   uds_sf_pkg::decode_type s2_dec;
   logic [6:0][7:0]        rsp_bytes;

   // payload bytes beyond the service parameters never shape a response
   logic unused_bytes;
   assign unused_bytes = ^{req_data_byte4, req_data_byte5, req_data_byte6, req_data_byte7};

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phys_id_ff    <= uds_sf_pkg::PHYS_ID_RESET;
         func_id_ff    <= uds_sf_pkg::FUNC_ID_RESET;
         app_major_ff  <= 8'd1;
         app_minor_ff  <= 8'd0;
         boot_major_ff <= 8'd1;
         boot_minor_ff <= 8'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            uds_sf_pkg::REG_PHYS_ID:    phys_id_ff    <= csr_data;
            uds_sf_pkg::REG_FUNC_ID:    func_id_ff    <= csr_data;
            uds_sf_pkg::REG_APP_MAJOR:  app_major_ff  <= csr_data[7:0];
            uds_sf_pkg::REG_APP_MINOR:  app_minor_ff  <= csr_data[7:0];
            uds_sf_pkg::REG_BOOT_MAJOR: boot_major_ff <= csr_data[7:0];
            uds_sf_pkg::REG_BOOT_MINOR: boot_minor_ff <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   uds_sf_filter u_filter (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .can_id       (req_can_id),
      .frame_length (req_frame_length),
      .data_byte0   (req_data_byte0),
      .data_byte1   (req_data_byte1),
      .data_byte2   (req_data_byte2),
      .data_byte3   (req_data_byte3),
      .phys_id      (phys_id_ff),
      .func_id      (func_id_ff),
      .out_valid    (s1_valid),
      .out_ready    (s1_ready),
      .out_frame    (s1_frame)
   );

   uds_sf_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_frame  (s1_frame),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_dec   (s2_dec)
   );

   uds_sf_format u_format (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s2_valid),
      .in_ready      (s2_ready),
      .in_dec        (s2_dec),
      .app_major     (app_major_ff),
      .app_minor     (app_minor_ff),
      .boot_major    (boot_major_ff),
      .boot_minor    (boot_minor_ff),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_len       (rsp_resp_byte0),
      .out_bytes     (rsp_bytes),
      .out_reset_req (rsp_reset_request)
   );

   assign rsp_resp_byte1 = rsp_bytes[0];
   assign rsp_resp_byte2 = rsp_bytes[1];
   assign rsp_resp_byte3 = rsp_bytes[2];
   assign rsp_resp_byte4 = rsp_bytes[3];
   // byte 7 is padding in every response; the xor term is masked to constant zero
   assign rsp_resp_byte5 = rsp_bytes[4];
   assign rsp_resp_byte6 = rsp_bytes[5];
   assign rsp_resp_byte7 = rsp_bytes[6] & {8{unused_bytes & 1'b0}};

endmodule

// ===== sim/uds_single_frame_responder_tb.sv =====
// Self-checking testbench for the UDS single-frame responder.
`timescale 1ns / 1ps

module uds_single_frame_responder_tb;

   localparam int IDLE_PERCENT = 9;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 40;

   localparam logic [2:0]  REG_SPARE_LOW   = 3'd6;
   localparam logic [2:0]  REG_SPARE_HIGH  = 3'd7;
   localparam logic [7:0]  VERSION_MAJOR_RESET = 8'd1;
   localparam logic [7:0]  VERSION_MINOR_RESET = 8'd0;
   localparam logic [15:0] DID_SYSTEM_NAME = 16'hF197;
   localparam logic [7:0]  SID_SECURITY    = 8'h27;

   typedef struct packed {
      logic [10:0]      can_id;
      logic [3:0]       frame_length;
      logic [0:7][7:0]  data;
   } can_frame_type;

   typedef struct packed {
      logic [2:0]       len;
      logic [1:7][7:0]  body;
      logic             reset_req;
   } diag_answer_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [10:0] req_can_id;
   logic [3:0]  req_frame_length;
   logic [7:0]  req_data_byte0, req_data_byte1, req_data_byte2, req_data_byte3;
   logic [7:0]  req_data_byte4, req_data_byte5, req_data_byte6, req_data_byte7;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_resp_byte0;
   logic [7:0]  rsp_resp_byte1, rsp_resp_byte2, rsp_resp_byte3, rsp_resp_byte4;
   logic [7:0]  rsp_resp_byte5, rsp_resp_byte6, rsp_resp_byte7;
   logic        rsp_reset_request;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [10:0] csr_data;

   // register shadow and session state of the predictor
   logic [10:0] cfg_phys_id   = uds_sf_pkg::PHYS_ID_RESET;
   logic [10:0] cfg_func_id   = uds_sf_pkg::FUNC_ID_RESET;
   logic [7:0]  cfg_app_major  = VERSION_MAJOR_RESET;
   logic [7:0]  cfg_app_minor  = VERSION_MINOR_RESET;
   logic [7:0]  cfg_boot_major = VERSION_MAJOR_RESET;
   logic [7:0]  cfg_boot_minor = VERSION_MINOR_RESET;
   logic [7:0]  session_level  = uds_sf_pkg::SESSION_DEFAULT;

   diag_answer_type pending_answers[$];

   bit steady_flow = 1'b0;
   int rsp_hold_left = 0;
   int cycle_count = 0;
   int error_count = 0;
   int frames_sent = 0;
   int register_writes = 0;
   int answers_checked = 0;
   int negatives_seen = 0;
   int resets_seen = 0;

   uds_single_frame_responder u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timeout with %0d answers outstanding", $time, pending_answers.size());
      $display("== FAIL ==");
      $finish;
   end

   // receiver: random stalls, a steady mode, and long hold-offs on request
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (steady_flow) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   function automatic diag_answer_type shape_answer(input int len,
                                                    input logic [0:5][7:0] bytes,
                                                    input bit flag);
      diag_answer_type a;
      a = '0;
      a.len = 3'(len);
      for (int i = 1; i <= len; i++) a.body[i] = bytes[i-1];
      a.reset_req = flag;
      return a;
   endfunction

   function automatic diag_answer_type refusal(input logic [7:0] sid, input logic [7:0] code);
      return shape_answer(3, {uds_sf_pkg::RSP_NEGATIVE, sid, code, 24'h0}, 1'b0);
   endfunction

   // returns 1 when the frame produces an answer; updates the session state
   function automatic bit predict_answer(input can_frame_type f, output diag_answer_type a);
      logic [3:0]  plen;
      logic [7:0]  sid;
      logic [15:0] did;
      a = '0;
      plen = f.data[0][3:0];
      sid = f.data[1];
      did = {f.data[2], f.data[3]};
      if (f.can_id != cfg_phys_id && f.can_id != cfg_func_id) return 1'b0;
      if (f.frame_length == 4'd0) return 1'b0;
      if (plen == 4'd0 || plen > 4'd7 || {1'b0, plen} + 5'd1 > {1'b0, f.frame_length})
         return 1'b0;
      case (sid)
         uds_sf_pkg::SID_SESSION: begin
            if (plen < 4'd2) begin
               a = refusal(sid, uds_sf_pkg::NRC_BAD_LENGTH);
            end else begin
               session_level = f.data[2];
               a = shape_answer(6, {uds_sf_pkg::RSP_SESSION, session_level,
                                    uds_sf_pkg::P2_HIGH, uds_sf_pkg::P2_LOW,
                                    uds_sf_pkg::P2_STAR_HIGH, uds_sf_pkg::P2_STAR_LOW},
                                1'b0);
            end
         end
         uds_sf_pkg::SID_ECU_RESET: begin
            if (plen < 4'd2) return 1'b0;
            a = shape_answer(2, {uds_sf_pkg::RSP_ECU_RESET, f.data[2], 32'h0}, 1'b1);
         end
         uds_sf_pkg::SID_READ_DID: begin
            if (plen < 4'd3) return 1'b0;
            if (did == uds_sf_pkg::DID_APP_VERSION)
               a = shape_answer(5, {uds_sf_pkg::RSP_READ_DID, f.data[2], f.data[3],
                                    cfg_app_major, cfg_app_minor, 8'h00}, 1'b0);
            else if (did == uds_sf_pkg::DID_BOOT_VERSION)
               a = shape_answer(5, {uds_sf_pkg::RSP_READ_DID, f.data[2], f.data[3],
                                    cfg_boot_major, cfg_boot_minor, 8'h00}, 1'b0);
            else
               a = refusal(sid, uds_sf_pkg::NRC_OUT_OF_RANGE);
         end
         uds_sf_pkg::SID_TESTER: begin
            if (plen >= 4'd2 && f.data[2] == uds_sf_pkg::TP_SUPPRESS) return 1'b0;
            a = shape_answer(1, {uds_sf_pkg::RSP_TESTER, 40'h0}, 1'b0);
         end
         default: a = refusal(sid, uds_sf_pkg::NRC_SERVICE_NOT_SUPPORTED);
      endcase
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endfunction

   // response checker
   always @(posedge clock) begin
      diag_answer_type seen, want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.len = rsp_resp_byte0;
         seen.body = {rsp_resp_byte1, rsp_resp_byte2, rsp_resp_byte3, rsp_resp_byte4,
                      rsp_resp_byte5, rsp_resp_byte6, rsp_resp_byte7};
         seen.reset_req = rsp_reset_request;
         if (pending_answers.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected response, expected none, got %h", $time, seen);
         end else begin
            want = pending_answers.pop_front();
            answers_checked++;
            if (want.body[1] == uds_sf_pkg::RSP_NEGATIVE) negatives_seen++;
            if (want.reset_req) resets_seen++;
            check_field("resp_byte0", want.len, seen.len);
            for (int i = 1; i <= 7; i++)
               check_field($sformatf("resp_byte%0d", i), want.body[i], seen.body[i]);
            check_field("reset_request", want.reset_req, seen.reset_req);
         end
      end
   end

   // offers one frame; valid stays high afterwards unless the next call idles
   task automatic send_frame(input can_frame_type f);
      diag_answer_type want;
      if (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_can_id <= f.can_id;
      req_frame_length <= f.frame_length;
      {req_data_byte0, req_data_byte1, req_data_byte2, req_data_byte3,
       req_data_byte4, req_data_byte5, req_data_byte6, req_data_byte7} <= f.data;
      do @(posedge clock); while (!req_ready);
      frames_sent++;
      if (predict_answer(f, want)) pending_answers.push_back(want);
   endtask

   // silent frames may still be in the pipeline when the last answer arrives
   task automatic go_idle();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [10:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      register_writes++;
      case (idx)
         uds_sf_pkg::REG_PHYS_ID:    cfg_phys_id = value;
         uds_sf_pkg::REG_FUNC_ID:    cfg_func_id = value;
         uds_sf_pkg::REG_APP_MAJOR:  cfg_app_major = value[7:0];
         uds_sf_pkg::REG_APP_MINOR:  cfg_app_minor = value[7:0];
         uds_sf_pkg::REG_BOOT_MAJOR: cfg_boot_major = value[7:0];
         uds_sf_pkg::REG_BOOT_MINOR: cfg_boot_minor = value[7:0];
         default: ;
      endcase
   endtask

   task automatic program_registers(input logic [10:0] phys, input logic [10:0] func,
                                    input logic [10:0] app_maj, input logic [10:0] app_min,
                                    input logic [10:0] boot_maj, input logic [10:0] boot_min,
                                    input bit stray);
      go_idle();
      write_register(uds_sf_pkg::REG_PHYS_ID, phys);
      write_register(uds_sf_pkg::REG_FUNC_ID, func);
      write_register(uds_sf_pkg::REG_APP_MAJOR, app_maj);
      write_register(uds_sf_pkg::REG_APP_MINOR, app_min);
      write_register(uds_sf_pkg::REG_BOOT_MAJOR, boot_maj);
      write_register(uds_sf_pkg::REG_BOOT_MINOR, boot_min);
      // writes past the register list must not land anywhere
      if (stray) begin
         write_register(REG_SPARE_LOW, 11'($urandom));
         write_register(REG_SPARE_HIGH, 11'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   function automatic can_frame_type make_frame(input logic [10:0] id,
                                                input logic [3:0] flen,
                                                input logic [0:7][7:0] bytes);
      can_frame_type f;
      f.can_id = id;
      f.frame_length = flen;
      f.data = bytes;
      return f;
   endfunction

   // mostly well-formed requests to this node, with some noise
   function automatic can_frame_type random_request();
      can_frame_type f;
      int plen, roll;
      f.data = {$urandom, $urandom};
      roll = $urandom_range(99);
      f.can_id = (roll < 45) ? cfg_phys_id : (roll < 85) ? cfg_func_id : 11'($urandom);
      plen = $urandom_range(1, 7);
      roll = $urandom_range(99);
      if (roll < 80) f.frame_length = 4'($urandom_range(plen + 1, 8));
      else if (roll < 88) f.frame_length = 4'($urandom_range(9, 15));
      else f.frame_length = 4'($urandom_range(0, 15));
      f.data[0][3:0] = ($urandom_range(99) < 8) ? 4'($urandom) : 4'(plen);
      roll = $urandom_range(99);
      if (roll < 22) begin
         f.data[1] = uds_sf_pkg::SID_SESSION;
      end else if (roll < 42) begin
         f.data[1] = uds_sf_pkg::SID_ECU_RESET;
      end else if (roll < 68) begin
         f.data[1] = uds_sf_pkg::SID_READ_DID;
         roll = $urandom_range(99);
         if (roll < 35) {f.data[2], f.data[3]} = uds_sf_pkg::DID_APP_VERSION;
         else if (roll < 70) {f.data[2], f.data[3]} = uds_sf_pkg::DID_BOOT_VERSION;
         else if (roll < 80) {f.data[2], f.data[3]} = DID_SYSTEM_NAME;
      end else if (roll < 88) begin
         f.data[1] = uds_sf_pkg::SID_TESTER;
         if ($urandom_range(99) < 40) f.data[2] = uds_sf_pkg::TP_SUPPRESS;
      end
      return f;
   endfunction

   task automatic test_directed();
      send_frame(make_frame(cfg_phys_id, 4'd8,
                            {8'h02, uds_sf_pkg::SID_SESSION, 8'h03, 40'h0}));
      send_frame(make_frame(cfg_phys_id, 4'd2,
                            {8'h01, uds_sf_pkg::SID_SESSION, {6{8'hFF}}}));
      // high nibble of byte 0 and bytes past the payload are don't-care
      send_frame(make_frame(cfg_phys_id, 4'd3,
                            {8'hF2, uds_sf_pkg::SID_SESSION, {6{8'hFF}}}));
      send_frame(make_frame(cfg_func_id, 4'd8,
                            {8'h02, uds_sf_pkg::SID_SESSION, 8'h00, 40'h0}));
      send_frame(make_frame(cfg_phys_id, 4'd8,
                            {8'h02, uds_sf_pkg::SID_ECU_RESET, 8'h01, 40'h0}));
      send_frame(make_frame(cfg_phys_id, 4'd8,
                            {8'h01, uds_sf_pkg::SID_ECU_RESET, 8'h01, 40'h0}));
      send_frame(make_frame(cfg_func_id, 4'd8,
                            {8'h03, uds_sf_pkg::SID_READ_DID, uds_sf_pkg::DID_APP_VERSION,
                             32'h0}));
      send_frame(make_frame(cfg_phys_id, 4'd8,
                            {8'h03, uds_sf_pkg::SID_READ_DID, uds_sf_pkg::DID_BOOT_VERSION,
                             32'h0}));
      send_frame(make_frame(cfg_phys_id, 4'd8,
                            {8'h03, uds_sf_pkg::SID_READ_DID, DID_SYSTEM_NAME, 32'h0}));
      send_frame(make_frame(cfg_phys_id, 4'd8,
                            {8'h02, uds_sf_pkg::SID_READ_DID, uds_sf_pkg::DID_APP_VERSION,
                             32'h0}));
      send_frame(make_frame(cfg_phys_id, 4'd8,
                            {8'h02, uds_sf_pkg::SID_TESTER, 8'h00, 40'h0}));
      send_frame(make_frame(cfg_func_id, 4'd8,
                            {8'h02, uds_sf_pkg::SID_TESTER, uds_sf_pkg::TP_SUPPRESS, 40'h0}));
      send_frame(make_frame(cfg_phys_id, 4'd8,
                            {8'h01, uds_sf_pkg::SID_TESTER, uds_sf_pkg::TP_SUPPRESS, 40'h0}));
      send_frame(make_frame(cfg_phys_id, 4'd8, {8'h02, SID_SECURITY, 8'h01, 40'h0}));
      send_frame(make_frame(cfg_phys_id ^ 11'h001, 4'd8,
                            {8'h02, uds_sf_pkg::SID_TESTER, 48'h0}));
      send_frame(make_frame(cfg_phys_id, 4'd0, {8'h02, uds_sf_pkg::SID_TESTER, 48'h0}));
      send_frame(make_frame(cfg_phys_id, 4'd8, {8'h00, uds_sf_pkg::SID_TESTER, 48'h0}));
      send_frame(make_frame(cfg_phys_id, 4'd15, {8'h08, uds_sf_pkg::SID_TESTER, 48'h0}));
      send_frame(make_frame(cfg_phys_id, 4'd15, {8'h0F, uds_sf_pkg::SID_TESTER, 48'h0}));
      send_frame(make_frame(cfg_phys_id, 4'd3,
                            {8'h03, uds_sf_pkg::SID_READ_DID, uds_sf_pkg::DID_APP_VERSION,
                             32'h0}));
      send_frame(make_frame(cfg_func_id, 4'd15,
                            {8'h07, uds_sf_pkg::SID_TESTER, 8'h00, {5{8'hFF}}}));
      send_frame(make_frame(cfg_func_id, 4'd15, {8{8'hFF}}));
      send_frame(make_frame(cfg_phys_id, 4'd8, 64'h0));
      go_idle();
   endtask

   task automatic test_random_traffic(input int count);
      repeat (count) send_frame(random_request());
   endtask

   task automatic test_register_settings();
      program_registers(11'h000, 11'h7FF, 11'h700, 11'h700, 11'h700, 11'h700, 1'b1);
      test_random_traffic(150);
      program_registers(11'h7FF, 11'h000, 11'h0FF, 11'h0FF, 11'h0FF, 11'h0FF, 1'b1);
      test_random_traffic(150);
      // both request IDs on the same value
      program_registers(11'h123, 11'h123, 11'h012, 11'h034, 11'h056, 11'h078, 1'b0);
      test_random_traffic(150);
      repeat (2) begin
         program_registers(11'($urandom), 11'($urandom), 11'($urandom), 11'($urandom),
                           11'($urandom), 11'($urandom), 1'b1);
         test_random_traffic(150);
      end
      program_registers(uds_sf_pkg::PHYS_ID_RESET, uds_sf_pkg::FUNC_ID_RESET,
                        11'd1, 11'd0, 11'd1, 11'd0, 1'b0);
   endtask

   task automatic test_steady_flow(input int count);
      go_idle();
      steady_flow = 1'b1;
      test_random_traffic(count);
      go_idle();
      steady_flow = 1'b0;
   endtask

   // receiver stops for a long while; the pipeline fills and req_ready drops
   task automatic test_backpressure();
      go_idle();
      rsp_hold_left <= LONG_HOLD;
      test_random_traffic(150);
      go_idle();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_can_id <= '0;
      req_frame_length <= '0;
      {req_data_byte0, req_data_byte1, req_data_byte2, req_data_byte3,
       req_data_byte4, req_data_byte5, req_data_byte6, req_data_byte7} <= '0;
      rsp_ready <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_traffic(400);
      test_register_settings();
      test_steady_flow(350);
      test_backpressure();
      go_idle();

      $display("Sent %0d frames, %0d register writes; checked %0d responses", frames_sent,
               register_writes, answers_checked);
      $display("(%0d negative, %0d with reset request), %0d errors", negatives_seen,
               resets_seen, error_count);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/uds_sf_pkg.sv
hdl/uds_sf_filter.sv
hdl/uds_sf_decode.sv
hdl/uds_sf_format.sv
hdl/uds_single_frame_responder.sv
sim/uds_single_frame_responder_tb.sv
